@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Needs clk and rst_n in scope where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// checked only out of reset
`define OTSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge
`define OTSU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hdl/otsu_pkg.sv @@
// Otsu threshold package: widths, state encoding, controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package otsu_pkg;
  localparam int unsigned MAX_PIXELS = 1048576;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned BINS   = 256;
  localparam int unsigned CNT_W  = 21;
  localparam int unsigned SUM_W  = 28;
  localparam int unsigned PRD_W  = 49;
  localparam int unsigned BAL_W  = 40;
  localparam int unsigned SQ_W   = 2 * PRD_W;
  localparam int unsigned MUL_W  = SQ_W + PRD_W;
  localparam int unsigned MCNT_W = 6;

  typedef enum logic [3:0] {
    S_IDLE, S_INC, S_INIT, S_RD, S_ACC, S_PROD, S_DIFF, S_SQ_GO,
    S_SQ_W, S_L_GO, S_L_W, S_R_GO, S_R_W, S_CMP, S_EMIT, S_SPARE
  } state_t;

  typedef enum logic [1:0] {
    MUL_SQ, MUL_LHS, MUL_RHS
  } mul_sel_t;

  typedef struct packed {
    logic     rd_en;
    logic     rd_scan;
    logic     inc;
    logic     init;
    logic     acc;
    logic     prod;
    logic     diff;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     sq_ld;
    logic     lhs_ld;
    logic     adopt;
    logic     t_inc;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic scan_any;
    logic more;
    logic mul_done;
    logic mul_busy;
    logic gt;
  } sts_t;
endpackage
`default_nettype wire

@@ hdl/otsu_ifc.sv @@
// Pixel and threshold channel interfaces (valid/ready).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface otsu_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       last;
  modport source (output valid, output pixel, output last, input ready);
  modport sink (input valid, input pixel, input last, output ready);
endinterface

interface otsu_thr_if;
  logic       valid;
  logic       ready;
  logic [7:0] threshold;
  modport source (output valid, output threshold, input ready);
  modport sink (input valid, input threshold, output ready);
endinterface
`default_nettype wire

@@ hdl/otsu_ctrl.sv @@
// Otsu controller: sequences histogram update, level scan and result transfer.
// Depends on otsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module otsu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire otsu_pkg::sts_t sts,
  output otsu_pkg::cmd_t     cmd
);
  import otsu_pkg::*;

  state_t state_r, state_nxt;
  logic   first_r, last_r, out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_INC;
      S_INC:   state_nxt = last_r ? S_INIT : S_IDLE;
      S_INIT:  state_nxt = sts.scan_any ? S_RD : S_EMIT;
      S_RD:    state_nxt = S_ACC;
      S_ACC:   state_nxt = S_PROD;
      S_PROD:  state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_SQ_GO;
      S_SQ_GO: state_nxt = S_SQ_W;
      S_SQ_W:  if (sts.mul_done) state_nxt = first_r ? S_CMP : S_L_GO;
      S_L_GO:  state_nxt = S_L_W;
      S_L_W:   if (sts.mul_done) state_nxt = S_R_GO;
      S_R_GO:  state_nxt = S_R_W;
      S_R_W:   if (sts.mul_done) state_nxt = S_CMP;
      S_CMP:   state_nxt = sts.more ? S_RD : S_EMIT;
      S_EMIT:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.rd_en  = in_valid;
      end
      S_INC:   cmd.inc = 1'b1;
      S_INIT:  cmd.init = 1'b1;
      S_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_scan = 1'b1;
      end
      S_ACC:   cmd.acc = 1'b1;
      S_PROD:  cmd.prod = 1'b1;
      S_DIFF:  cmd.diff = 1'b1;
      S_SQ_GO: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_SQ;
      end
      S_SQ_W:  cmd.sq_ld = sts.mul_done;
      S_L_GO: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_LHS;
      end
      S_L_W:   cmd.lhs_ld = sts.mul_done;
      S_R_GO: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_RHS;
      end
      S_R_W:   ;
      S_CMP: begin
        cmd.adopt = first_r || sts.gt;
        cmd.t_inc = sts.more;
      end
      S_EMIT:  cmd.emit = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_ready && in_valid) last_r <= in_last;
      if (cmd.init) first_r <= 1'b1;
      else if (cmd.adopt) first_r <= 1'b0;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

@@ hdl/otsu_dp.sv @@
// Otsu datapath: histogram memory, totals, scan accumulators, shift-add multiplier.
// Depends on otsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module otsu_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [7:0]     in_pixel,
  input  wire otsu_pkg::cmd_t cmd,
  output otsu_pkg::sts_t      sts,
  output logic [7:0]          threshold
);
  import otsu_pkg::*;

  logic [CNT_W-1:0] hist_mem [BINS];
  logic [BINS-1:0]  vld_r;
  logic [CNT_W-1:0] rd_data_r;
  logic             rd_vld_r;
  logic [PIX_W-1:0] rd_addr, px_r, t_r, low_r, high_r, best_level_r, thr_r;
  logic [CNT_W-1:0] bin, n_r, rc_r;
  logic [SUM_W-1:0] m_r, rw_r;
  logic [PRD_W-1:0] a_r, b_r, d_r;
  logic [BAL_W-1:0] q_r, best_q_r;
  logic [SQ_W-1:0]  sq_r, best_sq_r;
  logic [MUL_W-1:0] lhs_r, mul_a_r, mul_p_r;
  logic [PRD_W-1:0] mul_b_r;
  logic [MCNT_W-1:0] mul_cnt_r;
  logic             mul_busy_r, mul_done_r, room;

  assign rd_addr = cmd.rd_scan ? t_r : in_pixel;
  assign bin     = rd_vld_r ? rd_data_r : '0;
  assign room    = n_r < CNT_W'(MAX_PIXELS);

  // histogram store, registered read
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= hist_mem[rd_addr];
    end
    if (cmd.inc && room) begin
      hist_mem[px_r] <= bin + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      n_r      <= '0;
      m_r      <= '0;
      low_r    <= '1;
      high_r   <= '0;
    end else begin
      if (cmd.rd_en) rd_vld_r <= vld_r[rd_addr];
      if (cmd.emit) begin
        vld_r  <= '0;
        n_r    <= '0;
        m_r    <= '0;
        low_r  <= '1;
        high_r <= '0;
      end else if (cmd.inc && room) begin
        vld_r[px_r] <= 1'b1;
        n_r         <= n_r + CNT_W'(1);
        m_r         <= m_r + SUM_W'(px_r);
        if (px_r < low_r) low_r <= px_r;
        if (px_r > high_r) high_r <= px_r;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (cmd.rd_en && !cmd.rd_scan) px_r <= in_pixel;
    if (cmd.init) begin
      rc_r         <= '0;
      rw_r         <= '0;
      t_r          <= low_r;
      best_level_r <= low_r;
    end
    if (cmd.acc) begin
      rc_r <= rc_r + bin;
      rw_r <= rw_r + SUM_W'(t_r) * SUM_W'(bin);
    end
    if (cmd.prod) begin
      a_r <= PRD_W'(rw_r) * PRD_W'(n_r);
      b_r <= PRD_W'(m_r) * PRD_W'(rc_r);
      q_r <= BAL_W'(rc_r) * BAL_W'(n_r - rc_r);
    end
    if (cmd.diff) begin
      d_r <= (a_r > b_r) ? (a_r - b_r) : (b_r - a_r);
      if (q_r == '0) q_r <= BAL_W'(1);
    end
    if (cmd.sq_ld) sq_r <= mul_p_r[SQ_W-1:0];
    if (cmd.lhs_ld) lhs_r <= mul_p_r;
    if (cmd.adopt) begin
      best_sq_r    <= sq_r;
      best_q_r     <= q_r;
      best_level_r <= t_r;
    end
    if (cmd.t_inc) t_r <= t_r + PIX_W'(1);
    if (cmd.emit) thr_r <= best_level_r;
  end

  // shift-add multiplier, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
      mul_cnt_r  <= '0;
    end else begin
      mul_done_r <= 1'b0;
      if (cmd.mul_go) begin
        mul_busy_r <= 1'b1;
        mul_cnt_r  <= MCNT_W'(PRD_W);
      end else if (mul_busy_r) begin
        mul_cnt_r <= mul_cnt_r - MCNT_W'(1);
        if (mul_cnt_r == MCNT_W'(1)) begin
          mul_busy_r <= 1'b0;
          mul_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      mul_p_r <= '0;
      case (cmd.mul_sel)
        MUL_SQ: begin
          mul_a_r <= MUL_W'(d_r);
          mul_b_r <= d_r;
        end
        MUL_LHS: begin
          mul_a_r <= MUL_W'(sq_r);
          mul_b_r <= PRD_W'(best_q_r);
        end
        MUL_RHS: begin
          mul_a_r <= MUL_W'(best_sq_r);
          mul_b_r <= PRD_W'(q_r);
        end
        default: begin
          mul_a_r <= '0;
          mul_b_r <= '0;
        end
      endcase
    end else if (mul_busy_r) begin
      if (mul_b_r[0]) mul_p_r <= mul_p_r + mul_a_r;
      mul_a_r <= mul_a_r << 1;
      mul_b_r <= mul_b_r >> 1;
    end
  end

  assign sts.scan_any = low_r < high_r;
  assign sts.more     = ({1'b0, t_r} + 9'd1) < {1'b0, high_r};
  assign sts.mul_done = mul_done_r;
  assign sts.mul_busy = mul_busy_r;
  assign sts.gt       = lhs_r > mul_p_r;
  assign threshold    = thr_r;
endmodule
`default_nettype wire

@@ hdl/otsu_threshold.sv @@
// Otsu threshold top level. Pixels: each is accepted, then its bin updated.
// After the last pixel: update, init, a scan of each level from the lowest to one
// below the highest (read, accumulate, product, difference, square, and two more
// products past the lowest level, compare), emit; result valid the cycle after.
// The result waits in an output register while the next image streams in.
// Reset: synchronous active-low rst_n clears control, bin valid bits and totals.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module otsu_threshold (
  input  wire logic   clk,
  input  wire logic   rst_n,
  otsu_pix_if.sink    in_pix,
  otsu_thr_if.source  out_thr
);
  import otsu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  otsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_last   (in_pix.last),
    .in_ready  (in_pix.ready),
    .out_valid (out_thr.valid),
    .out_ready (out_thr.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  otsu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pixel  (in_pix.pixel),
    .cmd       (cmd),
    .sts       (sts),
    .threshold (out_thr.threshold)
  );

  `OTSU_ASSERT(a_pix_gap, (in_pix.valid && in_pix.ready) |=> !in_pix.ready, "pixel gap")
  `OTSU_ASSERT(a_out_src, $rose(out_thr.valid) |-> $past(cmd.emit), "result without emit")
  `OTSU_ASSERT_ALWAYS(a_mul_idle, cmd.mul_go |-> !sts.mul_busy, "multiplier restarted")
endmodule
`default_nettype wire
